[design/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define NPCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("npcs assertion failed");

// property checked at every rising clock edge, reset included
`define NPCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("npcs assertion failed");

`endif

[design/npcs_pkg.sv]
// types, constants and helper functions of the nearest palette color search
package npcs_pkg;

   localparam int IDX_W  = 7;
   localparam int COMP_W = 8;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int IDX_MAX = (2 ** IDX_W) - 1;

   localparam int PALETTE_DEPTH_DEF = 128;

   localparam logic [IDX_W-1:0] RANGE_FIRST_RESET = IDX_W'(10);
   localparam logic [IDX_W-1:0] RANGE_LAST_RESET  = IDX_W'(73);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_RANGE_FIRST = 1'b0,
      REG_RANGE_LAST  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } color_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [IDX_W-1:0] entry;
      color_type        pixel;
   } item_type;

   typedef struct packed {
      item_type          item;
      logic              found;
      logic [IDX_W-1:0]  best_idx;
      logic [DIST_W-1:0] best_dist;
      logic              pend_cand;
      logic [IDX_W-1:0]  pend_idx;
      logic [SQ_W-1:0]   sq_red;
      logic [SQ_W-1:0]   sq_green;
      logic [SQ_W-1:0]   sq_blue;
   } stage_type;

   function automatic logic [SQ_W-1:0] comp_sq(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return SQ_W'(diff) * SQ_W'(diff);
   endfunction

   // fold the pending candidate distance into the running best
   function automatic stage_type merge_best(input stage_type s);
      stage_type         r;
      logic [DIST_W-1:0] cand_dist;
      r = s;
      cand_dist = DIST_W'(s.sq_red) + DIST_W'(s.sq_green) + DIST_W'(s.sq_blue);
      if (s.pend_cand && (!s.found || (cand_dist < s.best_dist))) begin
         r.found     = 1'b1;
         r.best_idx  = s.pend_idx;
         r.best_dist = cand_dist;
      end
      return r;
   endfunction

endpackage

[design/npcs_channels.sv]
// request and response channel interfaces
interface npcs_req_if import npcs_pkg::*; ();
   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [IDX_W-1:0]  entry;
   logic [COMP_W-1:0] red;
   logic [COMP_W-1:0] green;
   logic [COMP_W-1:0] blue;

   modport source (output valid, opcode, entry, red, green, blue, input ready);
   modport sink (input valid, opcode, entry, red, green, blue, output ready);
endinterface

interface npcs_rsp_if import npcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] nearest_index;

   modport source (output valid, nearest_index, input ready);
   modport sink (input valid, nearest_index, output ready);
endinterface

[design/nearest_palette_color_search.sv]
// Nearest palette color search: maps an RGB pixel to the palette index of least squared
// distance among indices range_first..range_last, lowest index on ties, range_first when no
// index qualifies. Palette writes and queries share one request stream and take effect in
// order. The search is a systolic pipeline with one stage per palette entry, each stage
// holding its entry in a register, so one request enters every cycle unless the response
// stalls; a query passes through the input register, the chain of PALETTE_DEPTH compare
// stages and the response register. A stalled response halts the whole pipeline.
// Configuration writes are taken in any cycle but belong in idle periods; there is no
// clearing pass after reset.
`include "assert_macros.svh"

module nearest_palette_color_search import npcs_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   npcs_req_if.sink         req,
   npcs_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [IDX_W-1:0] csr_wdata
);

   logic [IDX_W-1:0] range_first_ff;
   logic [IDX_W-1:0] range_last_ff;
   logic             advance;

   logic             vld [0:PALETTE_DEPTH];
   stage_type        stg [0:PALETTE_DEPTH];
   stage_type        head_in;
   logic             head_valid_ff;
   stage_type        head_ff;

   stage_type        tail_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_first_ff <= RANGE_FIRST_RESET;
         range_last_ff  <= RANGE_LAST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANGE_FIRST: range_first_ff <= csr_wdata;
            REG_RANGE_LAST:  range_last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      head_in                 = '0;
      head_in.item.opcode     = req.opcode;
      head_in.item.entry      = req.entry;
      head_in.item.pixel.red  = req.red;
      head_in.item.pixel.green = req.green;
      head_in.item.pixel.blue = req.blue;
      head_in.best_idx        = range_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else if (advance) begin
         head_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_ff <= head_in;
      end
   end

   assign vld[0] = head_valid_ff;
   assign stg[0] = head_ff;

   // one stage per palette entry
   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      npcs_cell #(
         .K (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .range_first (range_first_ff),
         .range_last  (range_last_ff),
         .valid_i     (vld[k]),
         .stage_i     (stg[k]),
         .valid_o     (vld[k+1]),
         .stage_o     (stg[k+1])
      );
   end

   // last compare and response register
   assign tail_in      = merge_best(stg[PALETTE_DEPTH]);
   assign rsp_valid_in = vld[PALETTE_DEPTH] && (stg[PALETTE_DEPTH].item.opcode == OP_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_idx_ff <= tail_in.best_idx;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.nearest_index = rsp_idx_ff;

   `NPCS_ASSERT(a_result_in_range, clock, reset,
      rsp_valid_ff |-> (rsp_idx_ff == range_first_ff) ||
      ((range_first_ff <= rsp_idx_ff) && (rsp_idx_ff <= range_last_ff)))

   `NPCS_ASSERT(a_rsp_from_query, clock, reset,
      $rose(rsp_valid_ff) |-> $past(rsp_valid_in))

   `NPCS_ASSERT(a_tail_holds_on_stall, clock, reset,
      !advance |=> $stable(vld[PALETTE_DEPTH]) && $stable(stg[PALETTE_DEPTH].item)
      && $stable(stg[PALETTE_DEPTH].best_idx))

   `NPCS_ASSERT_ALWAYS(a_idle_after_reset, clock,
      $past(reset) |-> !rsp_valid_ff)

endmodule

[design/npcs_cell.sv]
// one pipeline stage holding one palette entry and its distance logic
module npcs_cell import npcs_pkg::*; #(
   parameter int K = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [IDX_W-1:0] range_first,
   input  logic [IDX_W-1:0] range_last,
   input  logic             valid_i,
   input  stage_type        stage_i,
   output logic             valid_o,
   output stage_type        stage_o
);

   localparam logic IN_RANGE = (K <= IDX_MAX);
   localparam logic [IDX_W-1:0] K_IDX = IDX_W'(K);

   color_type pal_ff;
   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;
   logic      wr_hit;

   assign wr_hit = valid_i && (stage_i.item.opcode == OP_WRITE) && IN_RANGE
                   && (stage_i.item.entry == K_IDX);

   always_comb begin
      stage_in           = merge_best(stage_i);
      stage_in.pend_cand = IN_RANGE && (range_first <= K_IDX) && (K_IDX <= range_last);
      stage_in.pend_idx  = K_IDX;
      stage_in.sq_red    = comp_sq(stage_i.item.pixel.red, pal_ff.red);
      stage_in.sq_green  = comp_sq(stage_i.item.pixel.green, pal_ff.green);
      stage_in.sq_blue   = comp_sq(stage_i.item.pixel.blue, pal_ff.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
      if (advance && wr_hit) begin
         pal_ff <= stage_i.item.pixel;
      end
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;

endmodule

[sim/nearest_palette_color_search_test.sv]
// self-checking testbench for the nearest palette color search
`timescale 1ns / 100ps

module nearest_palette_color_search_test;
   import npcs_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int SHADE_DEPTH = PALETTE_DEPTH_DEF;
   localparam int PHASE_ITEMS = 75;

   typedef struct {
      bit               is_csr;
      csr_reg_type      reg_sel;
      logic [IDX_W-1:0] value;
      opcode_type       op;
      logic [IDX_W-1:0] entry;
      color_type        px;
      bit               typed;
      logic [IDX_W-1:0] want;
   } script_row;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [0:0]       csr_index;
   logic [IDX_W-1:0] csr_wdata;

   npcs_req_if req ();
   npcs_rsp_if rsp ();

   nearest_palette_color_search #(.PALETTE_DEPTH(SHADE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   color_type        shade_mem [SHADE_DEPTH];
   logic [IDX_W-1:0] cfg_first;
   logic [IDX_W-1:0] cfg_last;
   logic [IDX_W-1:0] nearest_due [$];
   logic [IDX_W-1:0] due_idx;
   script_row        script [$];
   int               burst_left;
   int               mismatches;
   int               writes_sent;
   int               queries_sent;
   int               settings_used;

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   function automatic int unsigned sq_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   // lowest index of least squared distance within the candidate range
   function automatic logic [IDX_W-1:0] closest_shade(color_type px);
      int unsigned      best_d;
      int unsigned      d;
      int               i;
      logic [IDX_W-1:0] best;
      best   = cfg_first;
      best_d = 32'h7FFF_FFFF;
      for (i = cfg_first; i <= cfg_last; i++) begin
         d = sq_gap(px.red, shade_mem[i].red) + sq_gap(px.green, shade_mem[i].green)
           + sq_gap(px.blue, shade_mem[i].blue);
         if (d < best_d) begin
            best_d = d;
            best   = IDX_W'(i);
         end
      end
      return best;
   endfunction

   // mix of free colors, coarse levels and saturated channels so ties show up
   function automatic color_type rand_shade();
      logic [23:0] bits;
      int          c;
      int          style;
      int          lvl;
      style = $urandom_range(0, 3);
      bits  = 24'($urandom);
      for (c = 0; c < 3; c++) begin
         case (style)
            1: begin
               lvl = $urandom_range(0, 4);
               bits[c*8 +: 8] = (lvl == 4) ? 8'hFF : 8'(64 * lvl);
            end
            2: bits[c*8 +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: ;
         endcase
      end
      return color_type'(bits);
   endfunction

   function automatic void add_csr(csr_reg_type sel, logic [IDX_W-1:0] value);
      script_row row;
      row.is_csr  = 1'b1;
      row.reg_sel = sel;
      row.value   = value;
      row.op      = OP_WRITE;
      row.entry   = '0;
      row.px      = '0;
      row.typed   = 1'b0;
      row.want    = '0;
      script.push_back(row);
   endfunction

   function automatic void add_item(opcode_type op, logic [IDX_W-1:0] entry,
                                    logic [23:0] rgb, bit typed, logic [IDX_W-1:0] want);
      script_row row;
      row.is_csr  = 1'b0;
      row.reg_sel = REG_RANGE_FIRST;
      row.value   = '0;
      row.op      = op;
      row.entry   = entry;
      row.px      = color_type'(rgb);
      row.typed   = typed;
      row.want    = want;
      script.push_back(row);
   endfunction

   task automatic send_request(opcode_type op, logic [IDX_W-1:0] ent, color_type px,
                               bit typed = 1'b0, logic [IDX_W-1:0] want = '0);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req.valid  <= 1'b1;
      req.opcode <= op;
      req.entry  <= ent;
      req.red    <= px.red;
      req.green  <= px.green;
      req.blue   <= px.blue;
      do @(posedge clock); while (!req.ready);
      if (op == OP_WRITE) begin
         shade_mem[ent] = px;
         writes_sent++;
      end else begin
         nearest_due.push_back(typed ? want : closest_shade(px));
         queries_sent++;
      end
   endtask

   // wait for every result, then let trailing writes leave the pipeline
   task automatic drain_pipeline();
      int quiet;
      req.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (nearest_due.size() != 0);
      quiet = 0;
      while (quiet < SHADE_DEPTH + 4) begin
         @(posedge clock);
         if (rsp.ready) quiet++;
      end
   endtask

   task automatic write_csr(csr_reg_type sel, logic [IDX_W-1:0] value);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == REG_RANGE_FIRST) cfg_first = value;
      else cfg_last = value;
      settings_used++;
   endtask

   task automatic set_range(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
      write_csr(REG_RANGE_FIRST, first);
      write_csr(REG_RANGE_LAST, last);
   endtask

   initial begin
      int        mode;
      int        left;
      rsp.ready <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
         end
         left--;
         case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ($urandom_range(0, 1) != 0);
            default: rsp.ready <= ((left % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (nearest_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: nearest_index expected none, actual %0d",
                        $time, rsp.nearest_index);
         end else begin
            due_idx = nearest_due.pop_front();
            if (rsp.nearest_index !== due_idx) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t: nearest_index expected %0d, actual %0d",
                           $time, due_idx, rsp.nearest_index);
            end
         end
      end
   end

   initial begin
      #(2 * HALF_PERIOD * 400000);
      $display("timeout with %0d results outstanding", nearest_due.size());
      $display("** nearest_palette_color_search: FAILED **");
      $finish;
   end

   initial begin
      int               k;
      int               p;
      int               n;
      int               pick;
      logic [IDX_W-1:0] ent;
      logic [IDX_W-1:0] lo;
      color_type        px;

      reset      <= 1'b1;
      req.valid  <= 1'b0;
      req.opcode <= OP_WRITE;
      req.entry  <= '0;
      req.red    <= '0;
      req.green  <= '0;
      req.blue   <= '0;
      csr_we     <= 1'b0;
      csr_index  <= REG_RANGE_FIRST;
      csr_wdata  <= '0;
      cfg_first     = RANGE_FIRST_RESET;
      cfg_last      = RANGE_LAST_RESET;
      burst_left    = 0;
      mismatches    = 0;
      writes_sent   = 0;
      queries_sent  = 0;
      settings_used = 0;
      for (k = 0; k < SHADE_DEPTH; k++) shade_mem[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty range answers range_first without reading the palette
      add_csr(REG_RANGE_FIRST, 7'd5);
      add_csr(REG_RANGE_LAST, 7'd2);
      add_item(OP_QUERY, 7'd0, 24'h000000, 1'b1, 7'd5);
      add_item(OP_WRITE, 7'd0, 24'h000000, 1'b0, '0);
      add_item(OP_WRITE, 7'd1, 24'hFFFFFF, 1'b0, '0);
      add_item(OP_WRITE, 7'd2, 24'h000000, 1'b0, '0);
      add_item(OP_WRITE, 7'd3, 24'hFF0000, 1'b0, '0);
      add_item(OP_WRITE, 7'd4, 24'h0000FF, 1'b0, '0);
      add_item(OP_WRITE, 7'd127, 24'h808080, 1'b0, '0);
      add_item(OP_WRITE, 7'd126, 24'hFFFFFF, 1'b0, '0);
      // exact match and tie go to the lowest index
      add_csr(REG_RANGE_FIRST, 7'd0);
      add_csr(REG_RANGE_LAST, 7'd2);
      add_item(OP_QUERY, 7'd0, 24'h000000, 1'b1, 7'd0);
      add_item(OP_QUERY, 7'd127, 24'hFFFFFF, 1'b1, 7'd1);
      add_item(OP_QUERY, 7'd0, 24'h7F7F7F, 1'b1, 7'd0);
      add_item(OP_QUERY, 7'd0, 24'h808080, 1'b1, 7'd1);
      // single candidate at the largest distance
      add_csr(REG_RANGE_FIRST, 7'd1);
      add_csr(REG_RANGE_LAST, 7'd1);
      add_item(OP_QUERY, 7'd0, 24'h000000, 1'b1, 7'd1);
      add_csr(REG_RANGE_FIRST, 7'd0);
      add_csr(REG_RANGE_LAST, 7'd4);
      add_item(OP_QUERY, 7'd0, 24'h00FF00, 1'b0, '0);
      add_item(OP_QUERY, 7'd0, 24'hFE0102, 1'b0, '0);
      add_item(OP_QUERY, 7'd0, 24'h0000FF, 1'b1, 7'd4);
      // top of the index space
      add_csr(REG_RANGE_FIRST, 7'd126);
      add_csr(REG_RANGE_LAST, 7'd127);
      add_item(OP_QUERY, 7'd0, 24'hFFFFFF, 1'b1, 7'd126);
      add_item(OP_QUERY, 7'd0, 24'h000000, 1'b1, 7'd127);
      add_item(OP_QUERY, 7'd0, 24'h808080, 1'b1, 7'd127);
      add_csr(REG_RANGE_LAST, 7'd0);
      add_csr(REG_RANGE_FIRST, 7'd127);
      add_item(OP_QUERY, 7'd0, 24'h123456, 1'b1, 7'd127);
      add_csr(REG_RANGE_LAST, 7'd127);
      add_item(OP_QUERY, 7'd0, 24'hFFFFFF, 1'b1, 7'd127);

      foreach (script[k]) begin
         if (script[k].is_csr)
            write_csr(script[k].reg_sel, script[k].value);
         else
            send_request(script[k].op, script[k].entry, script[k].px,
                         script[k].typed, script[k].want);
      end

      // load the whole palette so every range is legal from here on
      for (k = 0; k < SHADE_DEPTH; k++)
         send_request(OP_WRITE, IDX_W'(k), rand_shade());

      for (p = 0; p < 8; p++) begin
         case (p)
            0: set_range(7'd0, 7'd127);
            1: set_range(RANGE_FIRST_RESET, RANGE_LAST_RESET);
            2: set_range(7'd127, 7'd0);
            3: set_range(7'd0, 7'd0);
            4: set_range(7'd127, 7'd127);
            5: set_range(7'd0, 7'd127);
            default: begin
               lo = IDX_W'($urandom_range(0, 120));
               set_range(lo, IDX_W'($urandom_range(lo, 127)));
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == 37) drain_pipeline();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               if ($urandom_range(0, 1) != 0 && cfg_first <= cfg_last)
                  ent = IDX_W'($urandom_range(cfg_first, cfg_last));
               else
                  ent = IDX_W'($urandom);
               send_request(OP_WRITE, ent, rand_shade());
            end else begin
               px = rand_shade();
               if (pick < 55 && cfg_first <= cfg_last) begin
                  px = shade_mem[$urandom_range(cfg_first, cfg_last)];
                  // near miss of a stored color
                  if (pick < 40) px.blue = px.blue ^ 8'($urandom_range(0, 3));
               end
               send_request(OP_QUERY, IDX_W'($urandom), px);
            end
         end
      end

      drain_pipeline();
      $display("run covered %0d palette writes and %0d queries over %0d register writes",
               writes_sent, queries_sent, settings_used);
      $display("including empty, single entry and full candidate ranges");
      if (mismatches == 0 && nearest_due.size() == 0) begin
         $display("** nearest_palette_color_search: PASSED **");
      end else begin
         $display("** nearest_palette_color_search: FAILED **");
      end
      $finish;
   end

endmodule
